// ===== src/pmstage_pkg.sv =====
// Shared types and constants for the pipeline memory stage.
// Holds instruction class codes, access size codes, the phase type and load extension.
// No dependencies; imported by pmstage_mem, pipeline_memory_stage_top, the checker and the testbench.
package pmstage_pkg;

   localparam int PM_ADDR_BITS = 16;

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_STORE = 4'd2;

   typedef enum logic [2:0] {
      SZ_SBYTE = 3'd0,
      SZ_UBYTE = 3'd1,
      SZ_SHALF = 3'd2,
      SZ_UHALF = 3'd3,
      SZ_WORD  = 3'd4
   } size_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_WAIT   = 2'd1,
      PH_ACCESS = 2'd2
   } phase_type;

   typedef struct packed {
      logic     rd;
      logic     wr;
      size_type size;
   } mem_ctl_type;

   // bytes arrive in access order, byte 0 in the low bits
   function automatic logic [31:0] load_extend(input size_type size, input logic [31:0] bytes);
      logic [31:0] v;
      v = '0;
      case (size)
         SZ_SBYTE: v = {{24{bytes[7]}}, bytes[7:0]};
         SZ_UBYTE: v = {24'd0, bytes[7:0]};
         SZ_SHALF: v = {{16{bytes[15]}}, bytes[15:0]};
         SZ_UHALF: v = {16'd0, bytes[15:0]};
         SZ_WORD:  v = bytes;
         default:  v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/pipeline_memory_stage_top.sv =====
// Memory stage of an in-order pipeline: load/store unit over a byte-lane data memory.
// Channels: req_ (one transaction per pipeline tick), rsp_ (one result per request).
// Each request transaction produces exactly one response transaction, in order.
// A load or store is captured and answered by a bubble (busy flag set); the two
// transactions after it are ignored as input, the first answered by a second bubble,
// the second returning the access result.
// Other instruction classes pass straight through when the stage is idle.
// Throughput: one transaction per cycle while rsp_tready does not hold the stage; the four
// byte-lane RAMs take one access per cycle, issued when the access tick is accepted.
// Two register stages (memory read register beside stage 1, then the output register);
// an accepted request is registered into stage 1 and moves on to the output register
// when that is free, where its response becomes valid.
// Reset: phase returns to idle and the pipeline empties; memory contents are kept.
// Stall: while rsp_tready is low the response is held; req_tready stays high while
// the inner stage is free, and drops only when both stages are full.
// Depends on pmstage_pkg and pmstage_mem.
module pipeline_memory_stage_top import pmstage_pkg::*; #(
   parameter int ADDR_BITS = PM_ADDR_BITS,
   localparam int REQ_BITS = 40 + ADDR_BITS,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // tdata: size_code[2:0], address[ADDR_BITS], data_in[32], dest_reg[5], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // tuser: op_code[3:0]
   input  logic [3:0]       req_tuser,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tdata: reg_out[4:0], value_out[36:5], busy_res[37], zero pad[39:38]
   output logic [39:0]      rsp_tdata,
   // tuser: op_out[3:0]
   output logic [3:0]       rsp_tuser,
   output logic             rsp_tlast
);

   size_type             req_size;
   logic [ADDR_BITS-1:0] req_addr;
   logic [31:0]          req_data;
   logic [4:0]           req_dest;
   logic                 req_fire;
   logic                 is_mem;

   phase_type            phase_ff, phase_in;

   logic [3:0]           held_op_ff;
   size_type             held_size_ff;
   logic [ADDR_BITS-1:0] held_addr_ff;
   logic [31:0]          held_data_ff;
   logic [4:0]           held_reg_ff;
   logic                 held_fin_ff;

   logic                 capture;
   logic [3:0]           res_op;
   logic [4:0]           res_reg;
   logic [31:0]          res_val;
   logic                 res_fin;
   logic                 res_busy;
   logic                 res_load;
   mem_ctl_type          mem_ctl;
   logic [31:0]          mem_rdata;

   logic                 s1_valid_ff;
   logic [3:0]           s1_op_ff;
   logic [4:0]           s1_reg_ff;
   logic [31:0]          s1_val_ff;
   logic                 s1_fin_ff;
   logic                 s1_busy_ff;
   logic                 s1_load_ff;
   size_type             s1_size_ff;

   logic                 out_valid_ff;
   logic [3:0]           out_op_ff;
   logic [4:0]           out_reg_ff;
   logic [31:0]          out_val_ff;
   logic                 out_fin_ff;
   logic                 out_busy_ff;

   logic                 o_ready;
   logic                 s1_move;

   assign req_size = size_type'(req_tdata[2:0]);
   assign req_addr = req_tdata[3 +: ADDR_BITS];
   assign req_data = req_tdata[3 + ADDR_BITS +: 32];
   assign req_dest = req_tdata[35 + ADDR_BITS +: 5];

   assign o_ready    = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && o_ready;
   assign req_tready = !s1_valid_ff || o_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_mem     = (req_tuser == OP_LOAD) || (req_tuser == OP_STORE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         case (phase_ff)
            PH_IDLE:   phase_in = is_mem ? PH_WAIT : PH_IDLE;
            PH_WAIT:   phase_in = PH_ACCESS;
            PH_ACCESS: phase_in = PH_IDLE;
            default:   phase_in = PH_IDLE;
         endcase
      end
   end

   // per-tick result and memory request
   always_comb begin
      capture  = 1'b0;
      res_op   = OP_NONE;
      res_reg  = '0;
      res_val  = '0;
      res_fin  = 1'b0;
      res_busy = 1'b1;
      res_load = 1'b0;
      mem_ctl  = '{rd: 1'b0, wr: 1'b0, size: held_size_ff};
      case (phase_ff)
         PH_IDLE: begin
            if (is_mem) begin
               capture = 1'b1;
            end else begin
               res_op   = req_tuser;
               res_reg  = req_dest;
               res_val  = req_data;
               res_fin  = req_tlast;
               res_busy = 1'b0;
            end
         end
         PH_WAIT: begin
            res_busy = 1'b1;
         end
         PH_ACCESS: begin
            res_op     = held_op_ff;
            res_reg    = held_reg_ff;
            res_fin    = held_fin_ff;
            res_busy   = 1'b0;
            res_load   = (held_op_ff == OP_LOAD);
            mem_ctl.rd = req_fire && (held_op_ff == OP_LOAD);
            mem_ctl.wr = req_fire && (held_op_ff == OP_STORE);
         end
         default: begin
            res_busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && capture) begin
         held_op_ff   <= req_tuser;
         held_size_ff <= req_size;
         held_addr_ff <= req_addr;
         held_data_ff <= req_data;
         held_reg_ff  <= req_dest;
         held_fin_ff  <= req_tlast;
      end
   end

   pmstage_mem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .address (held_addr_ff),
      .wdata   (held_data_ff),
      .rdata   (mem_rdata)
   );

   // stage 1: waits for the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= res_op;
         s1_reg_ff  <= res_reg;
         s1_val_ff  <= res_val;
         s1_fin_ff  <= res_fin;
         s1_busy_ff <= res_busy;
         s1_load_ff <= res_load;
         s1_size_ff <= held_size_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_op_ff   <= s1_op_ff;
         out_reg_ff  <= s1_reg_ff;
         out_val_ff  <= s1_load_ff ? load_extend(s1_size_ff, mem_rdata) : s1_val_ff;
         out_fin_ff  <= s1_fin_ff;
         out_busy_ff <= s1_busy_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_busy_ff, out_val_ff, out_reg_ff};
   assign rsp_tuser  = out_op_ff;
   assign rsp_tlast  = out_fin_ff;

   a_access_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_ACCESS) |=> (phase_ff == PH_IDLE))
      else $error("access tick did not return the phase to idle");

   a_mem_one_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd && mem_ctl.wr))
      else $error("memory read and write issued together");

   a_bubble_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_busy_ff) |-> (out_op_ff == OP_NONE && out_val_ff == '0))
      else $error("busy response carries instruction data");

   a_access_only_in_phase: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.rd || mem_ctl.wr) |-> (phase_ff == PH_ACCESS && req_fire))
      else $error("memory access outside the access tick");

endmodule

// ===== src/pmstage_mem.sv =====
// Byte-addressed data memory built from four byte-lane RAMs, one read or write per cycle.
// Handles unaligned accesses with address wrap; read data is registered.
// Depends on pmstage_pkg.
module pmstage_mem import pmstage_pkg::*; #(
   parameter int ADDR_BITS = PM_ADDR_BITS
) (
   input  logic                 clock,
   input  mem_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [31:0]          wdata,
   output logic [31:0]          rdata
);

   localparam int ROW_BITS   = ADDR_BITS - 2;
   localparam int LANE_DEPTH = 2 ** ROW_BITS;

   logic [1:0]  off;
   logic [1:0]  off_ff;
   logic [2:0]  nbytes;
   logic [7:0]  lane_q [4];

   assign off = address[1:0];

   always_comb begin
      case (ctl.size)
         SZ_SBYTE, SZ_UBYTE: nbytes = 3'd1;
         SZ_SHALF, SZ_UHALF: nbytes = 3'd2;
         SZ_WORD:            nbytes = 3'd4;
         default:            nbytes = 3'd0;
      endcase
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [7:0]          lane_mem [LANE_DEPTH];
      logic [7:0]          rd_ff;
      logic [1:0]          idx;
      logic [ROW_BITS-1:0] row;
      logic [7:0]          wbyte;
      logic                wr_en;

      // byte idx of the access lands in this lane; lanes below the offset wrap to the next row
      assign idx   = 2'(k) - off;
      assign row   = address[ADDR_BITS-1:2] + {{(ROW_BITS-1){1'b0}}, (2'(k) < off)};
      assign wbyte = wdata[{idx, 3'b000} +: 8];
      assign wr_en = ctl.wr && ({1'b0, idx} < nbytes);

      always_ff @(posedge clock) begin
         if (wr_en) begin
            lane_mem[row] <= wbyte;
         end
         if (ctl.rd) begin
            rd_ff <= lane_mem[row];
         end
      end

      assign lane_q[k] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         off_ff <= off;
      end
   end

   // rotate lanes back into access order
   always_comb begin
      logic [1:0] sel;
      rdata = '0;
      for (int i = 0; i < 4; i++) begin
         sel = off_ff + 2'(i);
         rdata[8*i +: 8] = lane_q[sel];
      end
   end

endmodule

// ===== dv/pmstage_result_checker.sv =====
// Checker for the pipeline memory stage: mirrors the stage and its byte memory,
// predicts one result per request transaction and compares the response stream.
// Depends on pmstage_pkg for instruction class, size and phase codes.
module pmstage_result_checker import pmstage_pkg::*; #(
   parameter int REQ_W = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [3:0]       req_tuser,
   input  logic             req_tlast,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [39:0]      rsp_tdata,
   input  logic [3:0]       rsp_tuser,
   input  logic             rsp_tlast,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // same order as the packed response fields below
   typedef struct packed {
      logic [3:0]  op;
      logic [4:0]  rd;
      logic [31:0] value;
      logic        fin;
      logic        busy;
   } writeback_type;

   phase_type     phase;
   logic [3:0]    held_op;
   logic [2:0]    held_size;
   logic [15:0]   held_addr;
   logic [31:0]   held_data;
   logic [4:0]    held_rd;
   logic          held_fin;
   logic [7:0]    shadow_mem [0:65535];
   writeback_type due_writebacks [$];
   writeback_type got, want;
   int            errors = 0;

   function automatic logic [7:0] mem_byte(input logic [15:0] addr, input int offset);
      return shadow_mem[16'(addr + offset)];
   endfunction

   function automatic logic [31:0] perform_access();
      logic [31:0] lanes;
      logic [31:0] v;
      v = '0;
      lanes = {mem_byte(held_addr, 3), mem_byte(held_addr, 2),
               mem_byte(held_addr, 1), mem_byte(held_addr, 0)};
      if (held_op == OP_LOAD) begin
         case (held_size)
            SZ_SBYTE: v = {{24{lanes[7]}}, lanes[7:0]};
            SZ_UBYTE: v = {24'd0, lanes[7:0]};
            SZ_SHALF: v = {{16{lanes[15]}}, lanes[15:0]};
            SZ_UHALF: v = {16'd0, lanes[15:0]};
            SZ_WORD:  v = lanes;
            default:  v = '0;
         endcase
      end else if (held_op == OP_STORE && held_size <= SZ_WORD) begin
         // signedness bit is don't-care for stores
         shadow_mem[held_addr] = held_data[7:0];
         if (held_size >= SZ_SHALF) shadow_mem[16'(held_addr + 1)] = held_data[15:8];
         if (held_size == SZ_WORD) begin
            shadow_mem[16'(held_addr + 2)] = held_data[23:16];
            shadow_mem[16'(held_addr + 3)] = held_data[31:24];
         end
      end
      return v;
   endfunction

   function automatic writeback_type advance_stage(input logic [3:0] op, input logic [2:0] size,
                                                    input logic [15:0] addr,
                                                    input logic [31:0] data,
                                                    input logic [4:0] rd, input logic fin);
      writeback_type r;
      r = '0;
      case (phase)
         PH_ACCESS: begin
            r.value = perform_access();
            r.op    = held_op;
            r.rd    = held_rd;
            r.fin   = held_fin;
            phase   = PH_IDLE;
         end
         PH_WAIT: phase = PH_ACCESS;
         default: begin
            if (op == OP_LOAD || op == OP_STORE) begin
               held_op   = op;
               held_size = size;
               held_addr = addr;
               held_data = data;
               held_rd   = rd;
               held_fin  = fin;
               phase     = PH_WAIT;
            end else begin
               r.op    = op;
               r.rd    = rd;
               r.value = data;
               r.fin   = fin;
               phase   = PH_IDLE;
            end
         end
      endcase
      r.busy = (phase != PH_IDLE);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase     = PH_IDLE;
         held_op   = OP_NONE;
         held_size = '0;
         held_addr = '0;
         held_data = '0;
         held_rd   = '0;
         held_fin  = 1'b0;
         due_writebacks.delete();
      end else begin
         if (req_tvalid && req_tready)
            due_writebacks.push_back(advance_stage(req_tuser, req_tdata[2:0], req_tdata[18:3],
                                                   req_tdata[50:19], req_tdata[55:51],
                                                   req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[4:0], rsp_tdata[36:5], rsp_tlast, rsp_tdata[37]};
            if (due_writebacks.size() == 0) begin
               errors++;
               $display("%0t: unexpected response transaction, expected none, got %h",
                        $time, got);
            end else begin
               want = due_writebacks.pop_front();
               compare_field("op_out", want.op, got.op);
               compare_field("reg_out", want.rd, got.rd);
               compare_field("value_out", want.value, got.value);
               compare_field("finish_out", want.fin, got.fin);
               compare_field("busy_res", want.busy, got.busy);
            end
         end
      end
      mismatches  <= errors;
      outstanding <= due_writebacks.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the pipeline memory stage testbench: clock, reset, request stimulus,
// response stalls, watchdog and verdict. Needs pmstage_pkg, the stage RTL and
// pmstage_result_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pmstage_pkg::*;

   localparam int REQ_W        = ((40 + PM_ADDR_BITS + 7) / 8) * 8;
   localparam int QUIET_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 620;
   localparam int SITE_DEPTH   = 64;

   localparam logic [3:0] OP_TOP_CLASS = 4'd15;
   localparam logic [2:0] SZ_BAD_LO    = 3'd5;
   localparam logic [2:0] SZ_BAD_HI    = 3'd7;

   typedef enum int {READY_FREE, READY_JITTER, READY_CHOKED} ready_mode_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [3:0]       req_tuser  = OP_NONE;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic [3:0]       rsp_tuser;
   logic             rsp_tlast;
   int               mismatches;
   int               outstanding;

   bit               written [0:65535];
   logic [15:0]      store_sites [$];
   int               burst_left = 0;
   ready_mode_type   ready_mode = READY_FREE;
   int               mode_left  = 0;
   int               quiet_cycles = 0;

   always #4 clock = ~clock;

   pipeline_memory_stage_top i_dut (.*);

   pmstage_result_checker #(.REQ_W(REQ_W)) i_checker (.*);

   // response side stalls on its own changing pattern
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (ready_mode)
         READY_FREE:   rsp_tready <= 1'b1;
         READY_JITTER: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:      rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[pipeline_memory_stage_top] ERROR");
         $finish;
      end
   end

   function automatic int span_bytes(input logic [2:0] size);
      if (size <= SZ_UBYTE) return 1;
      if (size <= SZ_UHALF) return 2;
      return 4;
   endfunction

   function automatic bit all_written(input logic [15:0] addr, input logic [2:0] size);
      for (int i = 0; i < span_bytes(size); i++)
         if (!written[16'(addr + i)]) return 1'b0;
      return 1'b1;
   endfunction

   // one request transaction, with bursts and gaps on the sender side
   task automatic send(input logic [3:0] op, input logic [2:0] size, input logic [15:0] addr,
                       input logic [31:0] data, input logic [4:0] rd, input logic fin);
      int gap;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rd, data, addr, size};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // a load or store, then the two ticks the stage spends busy (inputs ignored)
   task automatic send_access(input logic [3:0] op, input logic [2:0] size,
                              input logic [15:0] addr, input logic [31:0] data,
                              input logic [4:0] rd, input logic fin);
      send(op, size, addr, data, rd, fin);
      if (op == OP_STORE && size <= SZ_WORD) begin
         for (int i = 0; i < span_bytes(size); i++) written[16'(addr + i)] = 1'b1;
         store_sites.push_back(addr);
         if (store_sites.size() > SITE_DEPTH) void'(store_sites.pop_front());
      end
      repeat (2)
         send(4'($urandom_range(0, 15)), 3'($urandom), 16'($urandom), $urandom,
              5'($urandom), 1'($urandom));
   endtask

   task automatic random_store();
      logic [15:0] addr;
      logic [2:0]  size;
      // half the stores land around the wrap point so loads overlap them
      addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 63) - 32) : 16'($urandom);
      size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(SZ_BAD_LO, SZ_BAD_HI))
                                         : 3'($urandom_range(0, SZ_WORD));
      send_access(OP_STORE, size, addr, $urandom, 5'($urandom), 1'($urandom));
   endtask

   task automatic random_load();
      logic [15:0] addr, try_addr;
      logic [2:0]  size, try_size;
      if ($urandom_range(0, 19) == 0) begin
         size = 3'($urandom_range(SZ_BAD_LO, SZ_BAD_HI));
         addr = 16'($urandom);
      end else begin
         // only bytes already stored may be read
         addr = store_sites[$urandom_range(0, store_sites.size() - 1)];
         size = SZ_UBYTE;
         for (int tries = 0; tries < 8; tries++) begin
            try_addr = 16'(addr + $urandom_range(0, 3));
            try_size = 3'($urandom_range(0, SZ_WORD));
            if (all_written(try_addr, try_size)) begin
               addr = try_addr;
               size = try_size;
               break;
            end
         end
      end
      send_access(OP_LOAD, size, addr, $urandom, 5'($urandom), 1'($urandom));
   endtask

   task automatic random_passthrough();
      logic [3:0] op;
      op = 4'($urandom_range(0, 13));
      if (op != OP_NONE) op = op + 4'd2;
      send(op, 3'($urandom), 16'($urandom), $urandom, 5'($urandom), 1'($urandom));
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // word store across the top of memory, then every load size over it
      send_access(OP_STORE, SZ_WORD, 16'hFFFE, 32'h8081_7F80, 5'd1, 1'b0);
      send_access(OP_LOAD, SZ_SBYTE, 16'hFFFE, 32'h0, 5'd2, 1'b0);
      send_access(OP_LOAD, SZ_UBYTE, 16'hFFFE, 32'hFFFF_FFFF, 5'd3, 1'b1);
      send_access(OP_LOAD, SZ_SHALF, 16'hFFFF, 32'h0, 5'd4, 1'b0);
      send_access(OP_LOAD, SZ_UHALF, 16'hFFFF, 32'h0, 5'd5, 1'b0);
      send_access(OP_LOAD, SZ_WORD, 16'hFFFE, 32'h0, 5'd31, 1'b1);
      // every store size, adjacent and unaligned
      send_access(OP_STORE, SZ_SBYTE, 16'h1234, 32'hDEAD_BEEF, 5'd0, 1'b1);
      send_access(OP_STORE, SZ_UBYTE, 16'h1235, 32'h1234_5601, 5'd6, 1'b0);
      send_access(OP_STORE, SZ_SHALF, 16'h1236, 32'hAAAA_F00D, 5'd7, 1'b0);
      send_access(OP_STORE, SZ_UHALF, 16'h1238, 32'h5555_7777, 5'd8, 1'b0);
      send_access(OP_STORE, SZ_WORD, 16'h123A, 32'hFFFF_FFFF, 5'd9, 1'b0);
      send_access(OP_LOAD, SZ_WORD, 16'h1234, 32'h0, 5'd10, 1'b0);
      send_access(OP_LOAD, SZ_WORD, 16'h1237, 32'h0, 5'd11, 1'b0);
      send_access(OP_LOAD, SZ_SHALF, 16'h123B, 32'h0, 5'd12, 1'b0);
      send_access(OP_LOAD, SZ_SBYTE, 16'h1234, 32'h0, 5'd13, 1'b0);
      // undefined sizes: stores write nothing, loads read nothing
      send_access(OP_STORE, SZ_BAD_LO, 16'h2000, 32'h1111_1111, 5'd14, 1'b0);
      send_access(OP_STORE, SZ_BAD_HI, 16'h2001, 32'h2222_2222, 5'd15, 1'b0);
      send_access(OP_LOAD, SZ_BAD_LO, 16'hABCD, 32'h0, 5'd16, 1'b0);
      send_access(OP_LOAD, SZ_BAD_HI, 16'hFFFF, 32'h0, 5'd17, 1'b1);
      send(OP_NONE, SZ_WORD, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b1);
      send(OP_TOP_CLASS, SZ_SBYTE, 16'h0000, 32'h0000_0000, 5'd0, 1'b0);
      send(OP_TOP_CLASS, SZ_BAD_HI, 16'h5A5A, 32'hA5A5_A5A5, 5'd21, 1'b1);
      wait_all_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_all_results();
         pick = $urandom_range(0, 99);
         if (pick < 35) random_store();
         else if (pick < 70) random_load();
         else random_passthrough();
      end

      wait_all_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("[pipeline_memory_stage_top] OK");
      else $display("[pipeline_memory_stage_top] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
src/pmstage_pkg.sv
src/pmstage_mem.sv
src/pipeline_memory_stage_top.sv
dv/pmstage_result_checker.sv
dv/testbench.sv
